// File: rtl/core/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types, sizes and helpers of the running maximum filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int MAX_RADIUS      = 15;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int RADIUS_WIDTH    = 4;
  localparam int RING_DEPTH      = 2 * MAX_RADIUS + 1;
  localparam int CNT_WIDTH       = $clog2(RING_DEPTH + 1);
  localparam int MAX_EMIT        = 16;
  localparam int EMIT_WIDTH      = $clog2(MAX_EMIT + 1);
  localparam int GROUP_SIZE      = 4;
  localparam int NUM_GROUPS      = (RING_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIUS_BEFORE = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RADIUS_AFTER  = CFG_INDEX_WIDTH'(1);
  localparam logic [RADIUS_WIDTH-1:0]    RADIUS_RESET      = RADIUS_WIDTH'(1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    sample_t sample;
    logic    last_in_column;
  } in_item_t;

  typedef struct packed {
    sample_t max_value;
    logic    end_of_column;
  } out_item_t;

  // head of the item queue as seen by the back end
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  function automatic sample_t smax(sample_t a, sample_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CNT_WIDTH-1:0] clamp_radius(logic [RADIUS_WIDTH-1:0] r);
    if (int'(r) > MAX_RADIUS) begin
      return CNT_WIDTH'(MAX_RADIUS);
    end
    return CNT_WIDTH'(r);
  endfunction

endpackage

// File: rtl/core/rmf_front.sv
// ----------------------------------------------------------------------------
// rmf_front
// Input side: takes samples and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rmf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rmf_pkg::in_item_t    in_data,
  output rmf_pkg::queue_head_t q_head,
  input  logic                 q_pop
);
  import rmf_pkg::*;

  in_item_t                store_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr_r;
  logic [QPTR_WIDTH-1:0]   wr_ptr_nxt;
  logic [QPTR_WIDTH-1:0]   rd_ptr_r;
  logic [QPTR_WIDTH-1:0]   rd_ptr_nxt;
  logic [QPTR_WIDTH:0]     count_r;
  logic [QPTR_WIDTH:0]     count_nxt;
  logic                    push;
  logic                    pop;

  assign in_stall = (count_r == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// File: rtl/core/rmf_back.sv
// ----------------------------------------------------------------------------
// rmf_back
// Back end: sample window, column counters, result sequencer and a two-stage
// registered max tree feeding the output register.
// ----------------------------------------------------------------------------
module rmf_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rmf_pkg::queue_head_t                  q_head,
  output logic                                  q_pop,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rmf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rmf_pkg::RADIUS_WIDTH-1:0]      cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output rmf_pkg::out_item_t                    out_data
);
  import rmf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } back_state_t;

  back_state_t             state_r;
  back_state_t             state_nxt;
  sample_t                 ring_r [RING_DEPTH];
  logic [CNT_WIDTH-1:0]    seen_r;
  logic [CNT_WIDTH-1:0]    seen_nxt;
  logic [CNT_WIDTH-1:0]    pend_r;
  logic [CNT_WIDTH-1:0]    pend_nxt;
  logic [EMIT_WIDTH-1:0]   emits_r;
  logic [EMIT_WIDTH-1:0]   emits_nxt;
  logic                    last_r;
  logic                    last_nxt;
  logic [RADIUS_WIDTH-1:0] radius_before_r;
  logic [RADIUS_WIDTH-1:0] radius_before_nxt;
  logic [RADIUS_WIDTH-1:0] radius_after_r;
  logic [RADIUS_WIDTH-1:0] radius_after_nxt;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  sample_t                 s1_part_r [NUM_GROUPS];
  logic                    s1_eoc_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_item_t               out_data_r;

  logic [CNT_WIDTH-1:0]    r1;
  logic [CNT_WIDTH-1:0]    r2;
  logic                    out_ready;
  logic                    s1_ready;
  logic                    issuing;
  logic                    more;
  logic                    done;
  logic                    flush;
  logic [CNT_WIDTH-1:0]    pend_e;
  logic [EMIT_WIDTH-1:0]   emits_e;
  logic [CNT_WIDTH-1:0]    base_seen;
  logic [CNT_WIDTH-1:0]    base_pend;
  logic [CNT_WIDTH-1:0]    back_off;
  logic [CNT_WIDTH-1:0]    lo;
  logic [CNT_WIDTH-1:0]    hi;
  logic [CNT_WIDTH:0]      hi_full;
  logic [CNT_WIDTH-1:0]    seen_m1;
  logic [RING_DEPTH-1:0]   in_win;
  sample_t                 leaf [NUM_GROUPS*GROUP_SIZE];
  sample_t                 part [NUM_GROUPS];
  sample_t                 final_max;

  function automatic logic due(logic [CNT_WIDTH-1:0] pend, logic [EMIT_WIDTH-1:0] emits,
                               logic last, logic [CNT_WIDTH-1:0] rad);
    logic pend_ok;
    pend_ok = last ? (pend != '0) : (pend > rad);
    return pend_ok && (emits < EMIT_WIDTH'(MAX_EMIT));
  endfunction

  function automatic logic [CNT_WIDTH-1:0] sat_inc(logic [CNT_WIDTH-1:0] x);
    return (x < CNT_WIDTH'(RING_DEPTH)) ? x + 1'b1 : x;
  endfunction

  assign r1        = clamp_radius(radius_before_r);
  assign r2        = clamp_radius(radius_after_r);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config writes
  always_comb begin
    radius_before_nxt = radius_before_r;
    radius_after_nxt  = radius_after_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS_BEFORE: radius_before_nxt = cfg_data;
        CFG_RADIUS_AFTER:  radius_after_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    out_ready = !out_valid_r || !out_stall;
    s1_ready  = !s1_valid_r || out_ready;
    issuing   = (state_r == ST_ISSUE) && due(pend_r, emits_r, last_r, r2) && s1_ready;
    pend_e    = issuing ? pend_r - 1'b1 : pend_r;
    emits_e   = emits_r + EMIT_WIDTH'(issuing);
    more      = due(pend_e, emits_e, last_r, r2);
    done      = (state_r == ST_ISSUE) && !more;
    flush     = done && last_r;
    base_seen = flush ? '0 : seen_r;
    base_pend = flush ? '0 : pend_e;
    q_pop     = ((state_r == ST_IDLE) || done) && q_head.valid;

    seen_nxt  = q_pop ? sat_inc(base_seen) : base_seen;
    pend_nxt  = q_pop ? sat_inc(base_pend) : base_pend;
    emits_nxt = q_pop ? '0 : emits_e;
    last_nxt  = q_pop ? q_head.item.last_in_column : last_r;

    case (state_r)
      ST_IDLE:  state_nxt = q_pop ? ST_ISSUE : ST_IDLE;
      ST_ISSUE: state_nxt = (done && !q_pop) ? ST_IDLE : ST_ISSUE;
      default:  state_nxt = ST_IDLE;
    endcase

    s1_valid_nxt  = s1_ready ? issuing : s1_valid_r;
    out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  end

  // window of the oldest pending position, as offsets back from the newest sample
  always_comb begin
    back_off = pend_r - 1'b1;
    lo       = (back_off > r2) ? back_off - r2 : '0;
    hi_full  = {1'b0, back_off} + {1'b0, r1};
    seen_m1  = seen_r - 1'b1;
    hi       = (hi_full > {1'b0, seen_m1}) ? seen_m1 : hi_full[CNT_WIDTH-1:0];
    for (int k = 0; k < RING_DEPTH; k++) begin
      in_win[k] = (CNT_WIDTH'(k) >= lo) && (CNT_WIDTH'(k) <= hi);
    end
    for (int i = 0; i < NUM_GROUPS*GROUP_SIZE; i++) begin
      leaf[i] = SAMPLE_MIN;
    end
    for (int k = 0; k < RING_DEPTH; k++) begin
      if (in_win[k]) begin
        leaf[k] = ring_r[k];
      end
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part[g] = leaf[g*GROUP_SIZE];
      for (int j = 1; j < GROUP_SIZE; j++) begin
        part[g] = smax(part[g], leaf[g*GROUP_SIZE + j]);
      end
    end
  end

  always_comb begin
    final_max = s1_part_r[0];
    for (int g = 1; g < NUM_GROUPS; g++) begin
      final_max = smax(final_max, s1_part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      seen_r          <= '0;
      pend_r          <= '0;
      emits_r         <= '0;
      last_r          <= 1'b0;
      radius_before_r <= RADIUS_RESET;
      radius_after_r  <= RADIUS_RESET;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      seen_r          <= seen_nxt;
      pend_r          <= pend_nxt;
      emits_r         <= emits_nxt;
      last_r          <= last_nxt;
      radius_before_r <= radius_before_nxt;
      radius_after_r  <= radius_after_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // newest sample at offset zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ring_r[0] <= q_head.item.sample;
      for (int k = 1; k < RING_DEPTH; k++) begin
        ring_r[k] <= ring_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      s1_part_r <= part;
      s1_eoc_r  <= last_r && (pend_r == CNT_WIDTH'(1));
    end
    if (out_ready && s1_valid_r) begin
      out_data_r.max_value     <= final_max;
      out_data_r.end_of_column <= s1_eoc_r;
    end
  end

endmodule

// File: rtl/core/running_max_filter_1d.sv
// ----------------------------------------------------------------------------
// running_max_filter_1d
// Sliding-window maximum along a column of signed samples.
// ----------------------------------------------------------------------------
// Samples of a column enter on in_data with last_in_column set on the final
// one; each transfer takes place when in_valid is high and in_stall is low.
// For every position the block returns the maximum of the samples from
// radius_before earlier to radius_after later, clipped to the column, in
// position order on out_data, with end_of_column on the final result.
// Radii are written on the cfg channel (index 0 before, 1 after), only while
// the block is idle, a rule for the user that the block does not enforce;
// both reset to 1. A result passes the group-maximum and output registers.
// While the output is not stalled, the back end handles one sample per
// cycle, or one result per cycle when a sample releases several (up to
// radius_after + 1 at a column end), set by the single max tree. A four-entry
// queue takes samples in the meantime and raises in_stall when full.
// Reset empties the queue and the pipeline and clears the column counters.
// While out_stall is high the output register holds its result and the
// pipeline behind it fills, then the queue, then in_stall rises.
// ----------------------------------------------------------------------------
module running_max_filter_1d (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rmf_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rmf_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rmf_pkg::RADIUS_WIDTH-1:0]    cfg_data
);
  import rmf_pkg::*;

  queue_head_t q_head;
  logic        q_pop;

  rmf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  rmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/rmf_checker.sv
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the running maximum filter, bound to the top level.
// ----------------------------------------------------------------------------
module rmf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input rmf_pkg::in_item_t                   in_data,
  input logic                                out_valid,
  input logic                                out_stall,
  input rmf_pkg::out_item_t                  out_data
);
  import rmf_pkg::*;

  logic [7:0] outst_r;
  logic [7:0] outst_nxt;
  logic [7:0] lasts_r;
  logic [7:0] lasts_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // samples still owed a result, and column ends still owed a flagged result
  always_comb begin
    outst_nxt = outst_r + 8'(in_xfer) - 8'(out_xfer);
    lasts_nxt = lasts_r + 8'(in_xfer && in_data.last_in_column)
                        - 8'(out_xfer && out_data.end_of_column);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
      lasts_r <= '0;
    end else begin
      outst_r <= outst_nxt;
      lasts_r <= lasts_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outst_r != '0)
    else $error("result without an owed sample");

  a_eoc_matched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_column |-> lasts_r != '0)
    else $error("column end flagged without a column end transfer");

endmodule

bind running_max_filter_1d rmf_checker u_rmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb_running_max_filter_1d.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_max_filter_1d
// Self-checking bench for the sliding-window maximum filter.
// ----------------------------------------------------------------------------
// Columns of samples are pushed through the block under several radius
// settings, including both extremes and a radius change in the middle of a
// column. A scoreboard keeps its own window ring and column counters,
// predicts every result and checks each output transfer in order. Both
// sides idle in short random bursts, and once the receiver holds off long
// enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_running_max_filter_1d;
  import rmf_pkg::*;

  localparam int NUM_RANDOM  = 420;
  localparam int QUIET_TAIL  = 60;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 300000;

  class max_window_sb;
    sample_t   ring [RING_DEPTH];
    int        seen;
    int        pending;
    int        head;
    int        reach_back;
    int        reach_ahead;
    out_item_t expected [$];
    int        errors;
    int        shown;

    function new();
      foreach (ring[k]) ring[k] = '0;
      seen        = 0;
      pending     = 0;
      head        = 0;
      reach_back  = int'(RADIUS_RESET);
      reach_ahead = int'(RADIUS_RESET);
      errors      = 0;
      shown       = 0;
    endfunction

    function void note_sample(in_item_t it);
      int        r1, r2, d, lo, hi, k, emitted;
      sample_t   best;
      sample_t   v;
      out_item_t res;
      r1 = (reach_back > MAX_RADIUS) ? MAX_RADIUS : reach_back;
      r2 = (reach_ahead > MAX_RADIUS) ? MAX_RADIUS : reach_ahead;
      head = (head + 1) % RING_DEPTH;
      ring[head] = it.sample;
      if (seen < RING_DEPTH) seen++;
      if (pending < RING_DEPTH) pending++;
      emitted = 0;
      while (pending > 0 && emitted < MAX_EMIT && (it.last_in_column || pending > r2)) begin
        d  = pending - 1;
        lo = (d > r2) ? d - r2 : 0;
        hi = d + r1;
        if (hi > seen - 1) hi = seen - 1;
        best = ring[(head + RING_DEPTH - lo) % RING_DEPTH];
        for (k = lo + 1; k <= hi; k++) begin
          v = ring[(head + RING_DEPTH - k) % RING_DEPTH];
          if (v > best) best = v;
        end
        res.max_value     = best;
        res.end_of_column = it.last_in_column && (pending == 1);
        expected.push_back(res);
        pending--;
        emitted++;
      end
      if (it.last_in_column) begin
        seen    = 0;
        pending = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: max_value %0d end_of_column %0b",
                   got.max_value, got.end_of_column);
        end
        return;
      end
      want = expected.pop_front();
      if (got.max_value !== want.max_value || got.end_of_column !== want.end_of_column) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: max_value exp %0d got %0d, end_of_column exp %0b got %0b",
                   want.max_value, got.max_value, want.end_of_column, got.end_of_column);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  in_item_t                   in_data;
  logic                       out_valid;
  logic                       out_stall;
  out_item_t                  out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [RADIUS_WIDTH-1:0]    cfg_data;

  max_window_sb sb;
  bit           idle_on;
  bit           pressure_req;

  running_max_filter_1d u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: check each transfer, stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
        sb.check_result(out_data);
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        stall_left   = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t pack_sample(sample_t s, logic last);
    in_item_t it;
    it.sample         = s;
    it.last_in_column = last;
    return it;
  endfunction

  function automatic logic [RADIUS_WIDTH-1:0] pick_radius();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return RADIUS_WIDTH'(MAX_RADIUS);
      default: return RADIUS_WIDTH'($urandom_range(0, MAX_RADIUS));
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_sample(it);
  endtask

  // let every expected result out and the block settle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radii(input logic [RADIUS_WIDTH-1:0] span_back,
                             input logic [RADIUS_WIDTH-1:0] span_ahead);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RADIUS_BEFORE;
    cfg_data  <= span_back;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.reach_back = int'(span_back);
    cfg_index <= CFG_RADIUS_AFTER;
    cfg_data  <= span_ahead;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.reach_ahead = int'(span_ahead);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int      sent, col, len, style, split, i;
    sample_t cur;
    sb           = new();
    idle_on      = 1'b1;
    pressure_req = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radii: single-sample column, then extremes and alternating bits
    send_item(pack_sample(sample_t'(16'h7fff), 1'b1));
    send_item(pack_sample(SAMPLE_MIN, 1'b0));
    send_item(pack_sample(sample_t'(16'h7fff), 1'b0));
    send_item(pack_sample(sample_t'(-1), 1'b0));
    send_item(pack_sample(sample_t'(16'h5555), 1'b0));
    send_item(pack_sample(sample_t'(16'haaaa), 1'b1));

    // zero radii: result is the sample itself
    drain();
    write_radii('0, '0);
    send_item(pack_sample(sample_t'(-5), 1'b0));
    send_item(pack_sample(sample_t'(10), 1'b0));
    send_item(pack_sample(SAMPLE_MIN, 1'b1));

    // widest window, then radius_after drops to zero mid-column
    drain();
    write_radii(RADIUS_WIDTH'(MAX_RADIUS), RADIUS_WIDTH'(MAX_RADIUS));
    for (i = 0; i < 15; i++) send_item(pack_sample(sample_t'($urandom), 1'b0));
    drain();
    write_radii(RADIUS_WIDTH'(MAX_RADIUS), '0);
    send_item(pack_sample(sample_t'($urandom), 1'b0));
    send_item(pack_sample(sample_t'($urandom), 1'b1));

    // one result per sample while the receiver holds off
    drain();
    write_radii(RADIUS_WIDTH'(3), '0);
    pressure_req = 1'b1;

    sent = 0;
    col  = 0;
    while (sent < NUM_RANDOM) begin
      if (col > 0 && $urandom_range(0, 3) == 0) begin
        drain();
        write_radii(pick_radius(), pick_radius());
      end
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 70) : $urandom_range(1, 20);
      if (len > NUM_RANDOM - sent) len = NUM_RANDOM - sent;
      style = $urandom_range(0, 3);
      split = (len > 17 && $urandom_range(0, 5) == 0) ? $urandom_range(16, len - 1) : 0;
      cur   = sample_t'($urandom);
      for (i = 0; i < len; i++) begin
        if (split != 0 && i == split) begin
          drain();
          write_radii(pick_radius(), pick_radius());
        end
        idle_on = (sent < NUM_RANDOM - QUIET_TAIL);
        case (style)
          0: cur = sample_t'($urandom);
          1: cur = cur + sample_t'($urandom_range(0, 300));
          2: cur = cur - sample_t'($urandom_range(0, 300));
          default: begin
            case ($urandom_range(0, 3))
              0:       cur = SAMPLE_MIN;
              1:       cur = sample_t'(16'h7fff);
              2:       cur = '0;
              default: cur = sample_t'(-1);
            endcase
          end
        endcase
        send_item(pack_sample(cur, i == len - 1));
        sent++;
      end
      col++;
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rmf_pkg.sv
rtl/core/rmf_front.sv
rtl/core/rmf_back.sv
rtl/core/running_max_filter_1d.sv
rtl/core/rmf_checker.sv
test/tb_running_max_filter_1d.sv
